/* src/xeu_pkg.sv */
// ----------------------------------------------------------------------------
// xeu_pkg
// shared types, character codes and sizing helpers for the entity unescaper
// ----------------------------------------------------------------------------
package xeu_pkg;

  // default width of the numeric entity accumulator
  localparam int unsigned VALUE_BITS_DEF = 21;

  // character codes
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOT  = 8'h22;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_APOS  = 8'h27;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_LG    = 8'h67;
  localparam logic [7:0] CH_LL    = 8'h6C;
  localparam logic [7:0] CH_LM    = 8'h6D;
  localparam logic [7:0] CH_LQ    = 8'h71;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_NUL   = 8'h00;

  // largest value still emitted as a single byte
  localparam int unsigned BYTE_MAX = 32;

  // input transfer
  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_t;

  // output transfer
  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       run_last;
    logic       text_done;
  } out_t;

  // entity decoder mode
  typedef enum logic [4:0] {
    MODE_TEXT = 5'b00001,
    MODE_AMP  = 5'b00010,
    MODE_A    = 5'b00100,
    MODE_SKIP = 5'b01000,
    MODE_NUM  = 5'b10000
  } mode_e;

  // result sequencer
  typedef enum logic [3:0] {
    SEQ_IDLE = 4'b0001,
    SEQ_PEND = 4'b0010,
    SEQ_DIV  = 4'b0100,
    SEQ_NUM  = 4'b1000
  } seq_e;

  // number of decimal digits of the largest value of the given width
  function automatic int unsigned dec_digits(input int unsigned bits);
    longint unsigned v;
    int unsigned     n;
    v = (64'd1 << bits) - 64'd1;
    n = 0;
    for (int i = 0; i < 20; i++) begin
      if (v != 0) begin
        v = v / 10;
        n = n + 1;
      end
    end
    return n;
  endfunction

endpackage

/* src/xml_entity_unescaper.sv */
// ----------------------------------------------------------------------------
// xml_entity_unescaper
// decodes xml character entities in a byte stream, one byte per transfer
// ----------------------------------------------------------------------------
// flow: the input transfer loads the pending results, which then pass one by
//   one into the output register as it frees; a dropped or skipped byte leaves
//   the input ready, otherwise no new byte is taken until the last result of
//   the byte is registered; a re-emitted numeric entity of D digits takes one
//   step per digit on the shared divide-by-ten unit, then its D+3 result bytes
// reset: async active low, returns to text mode with an empty output register
// ----------------------------------------------------------------------------
module xml_entity_unescaper #(
  parameter int unsigned VALUE_BITS = xeu_pkg::VALUE_BITS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  xeu_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output xeu_pkg::out_t  out_data_o
);

  // digit buffer sizing
  localparam int unsigned NDIG = xeu_pkg::dec_digits(VALUE_BITS);
  localparam int unsigned IW   = $clog2(NDIG);
  localparam int unsigned CW   = $clog2(NDIG + 1);
  localparam int unsigned EW   = $clog2(NDIG + 3);

  // sequencer and decoder state
  xeu_pkg::seq_e  seq_q, seq_d;
  xeu_pkg::mode_e mode_q, mode_d;
  logic [2:0]            skip_q, skip_d;
  logic [VALUE_BITS-1:0] val_q, val_d;
  logic                  hex_q, hex_d;
  logic [3:0]            dcnt_q, dcnt_d;
  logic                  bad_q, bad_d;
  logic                  done_q, done_d;

  // pending simple results (one or two bytes, or a bare end marker)
  logic [7:0] pend0_q, pend0_d;
  logic [7:0] pend1_q, pend1_d;
  logic       pend_two_q, pend_two_d;
  logic       pend_chr_q, pend_chr_d;
  logic       pidx_q, pidx_d;

  // decimal re-emission: digits stored least significant first
  logic [3:0]    dig_q [NDIG];
  logic [CW-1:0] ndig_q, ndig_d;
  logic [EW-1:0] eptr_q, eptr_d;
  logic [EW-1:0] rd_ptr;

  // output register
  xeu_pkg::out_t out_q, out_d;
  logic          out_vld_q, out_vld_d;

  // shared units
  logic [VALUE_BITS-1:0] acc_val;
  logic                  acc_ok;
  logic [VALUE_BITS-1:0] div_quot;
  logic [3:0]            div_rem;

  // per-transfer decode results
  logic [7:0]    c;
  logic          in_fire;
  logic          out_load;
  logic [1:0]    res_n;
  logic [7:0]    res0;
  logic [7:0]    res1;
  logic          fin;
  logic          start_div;
  logic          bare;
  logic          num_ok;
  logic          emit_en;
  xeu_pkg::out_t emit;

  assign c           = in_data_i.text_byte;
  assign in_ready_o  = (seq_q == xeu_pkg::SEQ_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_load    = !out_vld_q || out_ready_i;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // entity is emitted only if it had digits, none bad, and a nonzero value
  assign num_ok = (dcnt_q != 4'd0) && !bad_q && (val_q != '0);

  // read pointer for most significant digit first
  assign rd_ptr = EW'(ndig_q) + EW'(1) - eptr_q;

  xeu_num_acc #(
    .VALUE_BITS (VALUE_BITS)
  ) u_acc (
    .value_i    (val_q),
    .hex_i      (hex_q),
    .char_i     (c),
    .value_o    (acc_val),
    .digit_ok_o (acc_ok)
  );

  // the divider reuses the value register as its dividend
  xeu_div10 #(
    .VALUE_BITS (VALUE_BITS)
  ) u_div (
    .value_i (val_q),
    .quot_o  (div_quot),
    .rem_o   (div_rem)
  );

  always_comb begin
    seq_d      = seq_q;
    mode_d     = mode_q;
    skip_d     = skip_q;
    val_d      = val_q;
    hex_d      = hex_q;
    dcnt_d     = dcnt_q;
    bad_d      = bad_q;
    done_d     = done_q;
    pend0_d    = pend0_q;
    pend1_d    = pend1_q;
    pend_two_d = pend_two_q;
    pend_chr_d = pend_chr_q;
    pidx_d     = pidx_q;
    ndig_d     = ndig_q;
    eptr_d     = eptr_q;
    res_n      = 2'd0;
    res0       = xeu_pkg::CH_NUL;
    res1       = xeu_pkg::CH_NUL;
    fin        = 1'b0;
    start_div  = 1'b0;
    bare       = 1'b0;
    emit_en    = 1'b0;
    emit       = '0;

    case (seq_q)
      xeu_pkg::SEQ_IDLE: begin
        if (in_fire) begin
          if (in_data_i.end_of_text) begin
            // flush whatever entity is open
            case (mode_q)
              xeu_pkg::MODE_AMP: begin
                res_n = 2'd1;
                res0  = xeu_pkg::CH_AMP;
              end
              xeu_pkg::MODE_A: begin
                res_n = 2'd1;
                res0  = xeu_pkg::CH_APOS;
              end
              xeu_pkg::MODE_NUM: begin
                fin = 1'b1;
              end
              default: ;
            endcase
            mode_d = xeu_pkg::MODE_TEXT;
            skip_d = 3'd0;
            val_d  = '0;
            hex_d  = 1'b0;
            dcnt_d = 4'd0;
            bad_d  = 1'b0;
          end else begin
            case (mode_q)
              xeu_pkg::MODE_AMP: begin
                if (c == xeu_pkg::CH_LL) begin
                  res_n  = 2'd1;
                  res0   = xeu_pkg::CH_LT;
                  skip_d = 3'd2;
                  mode_d = xeu_pkg::MODE_SKIP;
                end else if (c == xeu_pkg::CH_LG) begin
                  res_n  = 2'd1;
                  res0   = xeu_pkg::CH_GT;
                  skip_d = 3'd2;
                  mode_d = xeu_pkg::MODE_SKIP;
                end else if (c == xeu_pkg::CH_LQ) begin
                  res_n  = 2'd1;
                  res0   = xeu_pkg::CH_QUOT;
                  skip_d = 3'd4;
                  mode_d = xeu_pkg::MODE_SKIP;
                end else if (c == xeu_pkg::CH_LA) begin
                  mode_d = xeu_pkg::MODE_A;
                end else if (c == xeu_pkg::CH_HASH) begin
                  val_d  = '0;
                  hex_d  = 1'b0;
                  dcnt_d = 4'd0;
                  bad_d  = 1'b0;
                  mode_d = xeu_pkg::MODE_NUM;
                end else begin
                  // not an entity: ampersand passes with the byte, a nul is lost
                  res_n  = (c != xeu_pkg::CH_NUL) ? 2'd2 : 2'd1;
                  res0   = xeu_pkg::CH_AMP;
                  res1   = c;
                  mode_d = xeu_pkg::MODE_TEXT;
                end
              end
              xeu_pkg::MODE_A: begin
                res_n  = 2'd1;
                mode_d = xeu_pkg::MODE_SKIP;
                if (c == xeu_pkg::CH_LM) begin
                  res0   = xeu_pkg::CH_AMP;
                  skip_d = 3'd2;
                end else begin
                  res0   = xeu_pkg::CH_APOS;
                  skip_d = 3'd3;
                end
              end
              xeu_pkg::MODE_SKIP: begin
                if (skip_q <= 3'd1) begin
                  skip_d = 3'd0;
                  mode_d = xeu_pkg::MODE_TEXT;
                end else begin
                  skip_d = skip_q - 3'd1;
                end
              end
              xeu_pkg::MODE_NUM: begin
                if (c == xeu_pkg::CH_SEMI || c == xeu_pkg::CH_NUL) begin
                  fin = 1'b1;
                end else if (dcnt_q == 4'd0 && (c == xeu_pkg::CH_LX || c == xeu_pkg::CH_UX)) begin
                  hex_d  = 1'b1;
                  dcnt_d = 4'd1;
                end else begin
                  if (acc_ok) begin
                    val_d = acc_val;
                  end else begin
                    bad_d = 1'b1;
                  end
                  if (dcnt_q != 4'd15) begin
                    dcnt_d = dcnt_q + 4'd1;
                  end
                end
              end
              default: begin
                mode_d = xeu_pkg::MODE_TEXT;
                if (c == xeu_pkg::CH_AMP) begin
                  mode_d = xeu_pkg::MODE_AMP;
                end else if (c >= xeu_pkg::CH_SPACE) begin
                  res_n = 2'd1;
                  res0  = c;
                end
              end
            endcase
          end

          // close a numeric entity: small value as a byte, large one re-emitted, else dropped
          if (fin) begin
            if (num_ok) begin
              if (val_q <= VALUE_BITS'(xeu_pkg::BYTE_MAX)) begin
                res_n = 2'd1;
                res0  = val_q[7:0];
              end else begin
                start_div = 1'b1;
              end
            end
            val_d  = start_div ? val_q : '0;
            hex_d  = 1'b0;
            dcnt_d = 4'd0;
            bad_d  = 1'b0;
            mode_d = xeu_pkg::MODE_TEXT;
          end

          bare   = in_data_i.end_of_text && (res_n == 2'd0) && !start_div;
          done_d = in_data_i.end_of_text;

          if (start_div) begin
            seq_d  = xeu_pkg::SEQ_DIV;
            ndig_d = '0;
          end else if (res_n != 2'd0 || bare) begin
            seq_d      = xeu_pkg::SEQ_PEND;
            pend0_d    = res0;
            pend1_d    = res1;
            pend_two_d = (res_n == 2'd2);
            pend_chr_d = !bare;
            pidx_d     = 1'b0;
          end
        end
      end

      xeu_pkg::SEQ_PEND: begin
        if (out_load) begin
          emit_en        = 1'b1;
          emit.out_byte  = pidx_q ? pend1_q : pend0_q;
          emit.out_valid = pend_chr_q;
          emit.run_last  = pidx_q || !pend_two_q;
          emit.text_done = done_q;
          if (emit.run_last) begin
            seq_d = xeu_pkg::SEQ_IDLE;
          end else begin
            pidx_d = 1'b1;
          end
        end
      end

      xeu_pkg::SEQ_DIV: begin
        // one digit per cycle, value register ends at zero
        ndig_d = ndig_q + CW'(1);
        val_d  = div_quot;
        if (div_quot == '0) begin
          seq_d  = xeu_pkg::SEQ_NUM;
          eptr_d = '0;
        end
      end

      xeu_pkg::SEQ_NUM: begin
        if (out_load) begin
          emit_en        = 1'b1;
          emit.out_valid = 1'b1;
          emit.text_done = done_q;
          if (eptr_q == EW'(0)) begin
            emit.out_byte = xeu_pkg::CH_AMP;
          end else if (eptr_q == EW'(1)) begin
            emit.out_byte = xeu_pkg::CH_HASH;
          end else if (eptr_q == EW'(ndig_q) + EW'(2)) begin
            emit.out_byte = xeu_pkg::CH_SEMI;
            emit.run_last = 1'b1;
          end else begin
            emit.out_byte = xeu_pkg::CH_ZERO | {4'b0000, dig_q[rd_ptr[IW-1:0]]};
          end
          eptr_d = eptr_q + EW'(1);
          if (emit.run_last) begin
            seq_d = xeu_pkg::SEQ_IDLE;
          end
        end
      end

      default: begin
        seq_d = xeu_pkg::SEQ_IDLE;
      end
    endcase

    out_vld_d = (out_vld_q && !out_ready_i) || emit_en;
    out_d     = emit_en ? emit : out_q;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q      <= xeu_pkg::SEQ_IDLE;
      mode_q     <= xeu_pkg::MODE_TEXT;
      skip_q     <= 3'd0;
      val_q      <= '0;
      hex_q      <= 1'b0;
      dcnt_q     <= 4'd0;
      bad_q      <= 1'b0;
      done_q     <= 1'b0;
      pend_two_q <= 1'b0;
      pend_chr_q <= 1'b0;
      pidx_q     <= 1'b0;
      ndig_q     <= '0;
      eptr_q     <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      seq_q      <= seq_d;
      mode_q     <= mode_d;
      skip_q     <= skip_d;
      val_q      <= val_d;
      hex_q      <= hex_d;
      dcnt_q     <= dcnt_d;
      bad_q      <= bad_d;
      done_q     <= done_d;
      pend_two_q <= pend_two_d;
      pend_chr_q <= pend_chr_d;
      pidx_q     <= pidx_d;
      ndig_q     <= ndig_d;
      eptr_q     <= eptr_d;
      out_vld_q  <= out_vld_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    pend0_q <= pend0_d;
    pend1_q <= pend1_d;
    out_q   <= out_d;
    if (seq_q == xeu_pkg::SEQ_DIV) begin
      dig_q[ndig_q[IW-1:0]] <= div_rem;
    end
  end

endmodule

/* src/xeu_div10.sv */
// ----------------------------------------------------------------------------
// xeu_div10
// divide by ten through a reciprocal multiply, gives quotient and remainder
// ----------------------------------------------------------------------------
module xeu_div10 #(
  parameter int unsigned VALUE_BITS = xeu_pkg::VALUE_BITS_DEF
) (
  input  logic [VALUE_BITS-1:0] value_i,
  output logic [VALUE_BITS-1:0] quot_o,
  output logic [3:0]            rem_o
);

  // exact for every 32-bit dividend
  localparam logic [63:0] RECIP = 64'h0000_0000_CCCC_CCCD;

  logic [31:0] v32;
  logic [63:0] prod;
  logic [28:0] quot;
  logic [31:0] quot_x10;
  logic [31:0] rem_w;

  assign v32      = 32'(value_i);
  assign prod     = 64'(v32) * RECIP;
  assign quot     = prod[63:35];
  assign quot_x10 = {quot, 3'b000} + {2'b00, quot, 1'b0};
  assign rem_w    = v32 - quot_x10;
  assign rem_o    = rem_w[3:0];
  assign quot_o   = VALUE_BITS'(quot);

endmodule

/* src/xeu_num_acc.sv */
// ----------------------------------------------------------------------------
// xeu_num_acc
// one digit step of a numeric entity, decimal or hex, saturating
// ----------------------------------------------------------------------------
module xeu_num_acc #(
  parameter int unsigned VALUE_BITS = xeu_pkg::VALUE_BITS_DEF
) (
  input  logic [VALUE_BITS-1:0] value_i,
  input  logic                  hex_i,
  input  logic [7:0]            char_i,
  output logic [VALUE_BITS-1:0] value_o,
  output logic                  digit_ok_o
);

  logic [3:0]            digit;
  logic [VALUE_BITS+3:0] scaled;
  logic [VALUE_BITS+3:0] sum;

  always_comb begin
    digit      = 4'd0;
    digit_ok_o = 1'b0;
    if (char_i >= xeu_pkg::CH_ZERO && char_i <= xeu_pkg::CH_NINE) begin
      digit      = 4'(char_i - xeu_pkg::CH_ZERO);
      digit_ok_o = 1'b1;
    end else if (hex_i && char_i >= xeu_pkg::CH_LA && char_i <= xeu_pkg::CH_LF) begin
      digit      = 4'(char_i - xeu_pkg::CH_LA) + 4'd10;
      digit_ok_o = 1'b1;
    end else if (hex_i && char_i >= xeu_pkg::CH_UA && char_i <= xeu_pkg::CH_UF) begin
      digit      = 4'(char_i - xeu_pkg::CH_UA) + 4'd10;
      digit_ok_o = 1'b1;
    end
  end

  // times 16 or times 10 (8v + 2v)
  assign scaled = hex_i ? {value_i, 4'b0000}
                        : ({1'b0, value_i, 3'b000} + {3'b000, value_i, 1'b0});
  assign sum    = scaled + (VALUE_BITS+4)'(digit);

  assign value_o = (|sum[VALUE_BITS+3:VALUE_BITS]) ? {VALUE_BITS{1'b1}}
                                                   : sum[VALUE_BITS-1:0];

endmodule

/* src/xeu_checker.sv */
// ----------------------------------------------------------------------------
// xeu_checker
// port-level checks for the entity unescaper, bound to the top level
// ----------------------------------------------------------------------------
module xeu_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input xeu_pkg::in_t  in_data_i,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input xeu_pkg::out_t out_data_o
);

  // a result held back stays offered
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output transfer dropped before acceptance");

  // a result held back keeps its payload
  a_out_stable : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("output payload changed while stalled");

  // a bare marker only closes an end of text and carries no byte
  a_bare_marker : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.out_valid |->
      out_data_o.run_last && out_data_o.text_done && (out_data_o.out_byte == 8'd0))
    else $error("bare result outside end of text");

  // end of text always produces a result, so the input side closes
  a_end_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.end_of_text |=> !in_ready_o)
    else $error("end of text transfer produced no result");

endmodule

bind xml_entity_unescaper xeu_checker u_xeu_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

/* tb/xml_entity_unescaper_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// xml_entity_unescaper_tb
// drives escaped text through the unescaper and checks every decoded
// transfer against a behavioral model of the decoder kept inside the bench;
// directed entity cases first, then random documents with idle bursts,
// a long output stall and a final gap-free stretch
// ----------------------------------------------------------------------------
module xml_entity_unescaper_tb;

  // largest accumulated entity value at the default width
  localparam longint unsigned NUM_MAX = (64'd1 << xeu_pkg::VALUE_BITS_DEF) - 64'd1;

  logic           clk = 1'b0;
  logic           rst_ni = 1'b0;
  logic           in_valid = 1'b0;
  logic           in_ready;
  xeu_pkg::in_t   in_data = '0;
  logic           out_valid;
  logic           out_ready = 1'b0;
  xeu_pkg::out_t  out_data;

  // idle burst enables for each side, long output stall request in cycles
  bit          sender_gaps = 1'b0;
  bit          receiver_gaps = 1'b0;
  int unsigned hold_off_cycles = 0;

  int unsigned items_sent = 0;
  int unsigned mismatch_cnt = 0;

  // decoder state of the bench model
  xeu_pkg::mode_e  dec_mode = xeu_pkg::MODE_TEXT;
  int unsigned     skip_cnt = 0;
  longint unsigned num_acc = 0;
  bit              num_hex = 1'b0;
  int unsigned     num_chars = 0;
  bit              num_bad = 1'b0;

  // characters produced by the current input byte, and all still awaited
  xeu_pkg::out_t step_out[$];
  xeu_pkg::out_t decoded_fifo[$];
  // bytes of the text fragment being built for sending
  logic [7:0]    text_run[$];

  xml_entity_unescaper dut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  // 4 ns clock
  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // --------------------------------------------------------------------------
  // decoder model
  // --------------------------------------------------------------------------

  function automatic void emit(input logic [7:0] ch, input logic vld);
    xeu_pkg::out_t r;
    r = '{out_byte: ch, out_valid: vld, run_last: 1'b0, text_done: 1'b0};
    step_out.push_back(r);
  endfunction

  function automatic void clear_entity();
    num_acc   = 0;
    num_hex   = 1'b0;
    num_chars = 0;
    num_bad   = 1'b0;
  endfunction

  // close a numeric entity: zero, empty or bad is dropped, 1..32 becomes a
  // single byte, anything larger is written back out in decimal
  function automatic void close_numeric();
    string digits;
    if (num_chars != 0 && !num_bad && num_acc != 0) begin
      if (num_acc <= xeu_pkg::BYTE_MAX) begin
        emit(num_acc[7:0], 1'b1);
      end else begin
        digits = $sformatf("%0d", num_acc);
        emit(xeu_pkg::CH_AMP, 1'b1);
        emit(xeu_pkg::CH_HASH, 1'b1);
        for (int i = 0; i < digits.len(); i++) emit(digits[i], 1'b1);
        emit(xeu_pkg::CH_SEMI, 1'b1);
      end
    end
    clear_entity();
    dec_mode = xeu_pkg::MODE_TEXT;
  endfunction

  // decode one accepted input transfer and queue the characters it yields
  function automatic void unescape_byte(input logic [7:0] ch, input logic eot);
    int unsigned d;
    bit          ok;
    step_out.delete();
    if (eot) begin
      // terminator flushes whatever entity is open
      case (dec_mode)
        xeu_pkg::MODE_AMP: emit(xeu_pkg::CH_AMP, 1'b1);
        xeu_pkg::MODE_A:   emit(xeu_pkg::CH_APOS, 1'b1);
        xeu_pkg::MODE_NUM: close_numeric();
        default: ;
      endcase
      dec_mode = xeu_pkg::MODE_TEXT;
      skip_cnt = 0;
      clear_entity();
      if (step_out.size() == 0) emit(xeu_pkg::CH_NUL, 1'b0);
      foreach (step_out[i]) step_out[i].text_done = 1'b1;
    end else begin
      case (dec_mode)
        xeu_pkg::MODE_AMP: begin
          if (ch == xeu_pkg::CH_LL) begin
            emit(xeu_pkg::CH_LT, 1'b1);
            skip_cnt = 2;
            dec_mode = xeu_pkg::MODE_SKIP;
          end else if (ch == xeu_pkg::CH_LG) begin
            emit(xeu_pkg::CH_GT, 1'b1);
            skip_cnt = 2;
            dec_mode = xeu_pkg::MODE_SKIP;
          end else if (ch == xeu_pkg::CH_LQ) begin
            emit(xeu_pkg::CH_QUOT, 1'b1);
            skip_cnt = 4;
            dec_mode = xeu_pkg::MODE_SKIP;
          end else if (ch == xeu_pkg::CH_LA) begin
            dec_mode = xeu_pkg::MODE_A;
          end else if (ch == xeu_pkg::CH_HASH) begin
            clear_entity();
            dec_mode = xeu_pkg::MODE_NUM;
          end else begin
            // not an entity after all, pass the ampersand and any nonzero byte
            emit(xeu_pkg::CH_AMP, 1'b1);
            if (ch != xeu_pkg::CH_NUL) emit(ch, 1'b1);
            dec_mode = xeu_pkg::MODE_TEXT;
          end
        end
        xeu_pkg::MODE_A: begin
          // "&am" is taken as amp, any other second letter as apos
          emit((ch == xeu_pkg::CH_LM) ? xeu_pkg::CH_AMP : xeu_pkg::CH_APOS, 1'b1);
          skip_cnt = (ch == xeu_pkg::CH_LM) ? 2 : 3;
          dec_mode = xeu_pkg::MODE_SKIP;
        end
        xeu_pkg::MODE_SKIP: begin
          if (skip_cnt <= 1) begin
            skip_cnt = 0;
            dec_mode = xeu_pkg::MODE_TEXT;
          end else begin
            skip_cnt--;
          end
        end
        xeu_pkg::MODE_NUM: begin
          if (ch == xeu_pkg::CH_SEMI || ch == xeu_pkg::CH_NUL) begin
            close_numeric();
          end else if (num_chars == 0 && (ch == xeu_pkg::CH_LX || ch == xeu_pkg::CH_UX)) begin
            num_hex   = 1'b1;
            num_chars = 1;
          end else begin
            ok = 1'b1;
            d  = 0;
            if (ch >= xeu_pkg::CH_ZERO && ch <= xeu_pkg::CH_NINE) begin
              d = 32'(ch - xeu_pkg::CH_ZERO);
            end else if (num_hex && ch >= xeu_pkg::CH_LA && ch <= xeu_pkg::CH_LF) begin
              d = 32'(ch - xeu_pkg::CH_LA) + 10;
            end else if (num_hex && ch >= xeu_pkg::CH_UA && ch <= xeu_pkg::CH_UF) begin
              d = 32'(ch - xeu_pkg::CH_UA) + 10;
            end else begin
              ok = 1'b0;
            end
            if (!ok) begin
              num_bad = 1'b1;
            end else begin
              num_acc = num_acc * (num_hex ? 64'd16 : 64'd10) + 64'(d);
              if (num_acc > NUM_MAX) num_acc = NUM_MAX;
            end
            if (num_chars < 15) num_chars++;
          end
        end
        default: begin
          dec_mode = xeu_pkg::MODE_TEXT;
          if (ch == xeu_pkg::CH_AMP) dec_mode = xeu_pkg::MODE_AMP;
          else if (ch >= xeu_pkg::CH_SPACE) emit(ch, 1'b1);
        end
      endcase
    end
    if (step_out.size() != 0) step_out[step_out.size() - 1].run_last = 1'b1;
    foreach (step_out[i]) decoded_fifo.push_back(step_out[i]);
  endfunction

  // --------------------------------------------------------------------------
  // input side
  // --------------------------------------------------------------------------

  // offer one byte, hold it until the transfer happens, then model it;
  // valid stays high into the next call unless an idle burst is taken
  task automatic push_text(input logic [7:0] b, input logic eot);
    @(negedge clk);
    if (sender_gaps && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{text_byte: b, end_of_text: eot};
    do @(posedge clk); while (!in_ready);
    unescape_byte(b, eot);
    items_sent++;
  endtask

  function automatic void append_str(input string s);
    for (int i = 0; i < s.len(); i++) text_run.push_back(s[i]);
  endfunction

  task automatic send_run();
    foreach (text_run[i]) push_text(text_run[i], 1'b0);
    text_run.delete();
  endtask

  // directed fragment, optionally closed by an end-of-text transfer
  task automatic send_text(input string s, input bit then_end);
    append_str(s);
    send_run();
    if (then_end) push_text(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // random documents: entities with random content, some of them broken,
  // plain runs, raw noise and terminators
  task automatic random_text(input int unsigned n);
    int unsigned     stop_at;
    int unsigned     pick;
    int unsigned     idx;
    logic [7:0]      ch;
    longint unsigned num;
    bit              hex;
    bit              end_after;
    string           digs;
    stop_at = items_sent + n;
    while (items_sent < stop_at) begin
      end_after = 1'b0;
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        // plain printable run
        repeat ($urandom_range(1, 6)) begin
          ch = 8'($urandom_range(32, 255));
          if (ch == xeu_pkg::CH_AMP) ch = 8'h21;
          text_run.push_back(ch);
        end
      end else if (pick < 45) begin
        case ($urandom_range(0, 4))
          0: append_str("&lt;");
          1: append_str("&gt;");
          2: append_str("&quot;");
          3: append_str("&amp;");
          default: append_str("&apos;");
        endcase
        // broken named entity: any byte after the ampersand
        if ($urandom_range(0, 5) == 0) text_run[1] = 8'($urandom_range(0, 255));
      end else if (pick < 75) begin
        case ($urandom_range(0, 3))
          0: num = 64'($urandom_range(0, 40));
          1: num = 64'($urandom_range(33, 99999));
          2: num = 64'($urandom());
          default: num = 64'($urandom_range(1 << 20, (1 << 21) + 8));
        endcase
        hex = 1'($urandom_range(0, 1));
        if (!hex) append_str("&#");
        else if ($urandom_range(0, 1) == 0) append_str("&#x");
        else append_str("&#X");
        digs = hex ? $sformatf("%0h", num) : $sformatf("%0d", num);
        if (hex && $urandom_range(0, 1) == 0) digs = digs.toupper();
        if ($urandom_range(0, 5) == 0) digs = {"0", digs};
        if ($urandom_range(0, 11) == 0) digs = "";
        append_str(digs);
        // bad digit, a late x, or an early terminator somewhere inside
        if (text_run.size() > 2 && $urandom_range(0, 6) == 0) begin
          idx = $urandom_range(2, text_run.size() - 1);
          text_run[idx] = ($urandom_range(0, 2) == 0) ? xeu_pkg::CH_LX
                                                      : 8'($urandom_range(0, 255));
        end
        case ($urandom_range(0, 9))
          8: text_run.push_back(xeu_pkg::CH_NUL);
          9: end_after = 1'b1;
          default: text_run.push_back(xeu_pkg::CH_SEMI);
        endcase
      end else if (pick < 83) begin
        end_after = 1'b1;
      end else begin
        // raw noise, control bytes and stray ampersands included
        repeat ($urandom_range(1, 4)) text_run.push_back(8'($urandom_range(0, 255)));
      end
      send_run();
      if (end_after) push_text(8'($urandom_range(0, 255)), 1'b1);
    end
  endtask

  // --------------------------------------------------------------------------
  // output side
  // --------------------------------------------------------------------------

  // ready driver: short random bursts, or a long hold on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_off_cycles != 0) begin
        out_ready <= 1'b0;
        repeat (hold_off_cycles) @(negedge clk);
        hold_off_cycles = 0;
        out_ready <= 1'b1;
      end else if (receiver_gaps && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(negedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic flag_error(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) $display("%0t ns: %s", $time, msg);
  endtask

  // compare each output transfer with the oldest awaited character
  always @(posedge clk) begin
    xeu_pkg::out_t exp;
    if (rst_ni && out_valid && out_ready) begin
      if (decoded_fifo.size() == 0) begin
        flag_error($sformatf("unexpected transfer byte=%h valid=%b last=%b done=%b",
                             out_data.out_byte, out_data.out_valid,
                             out_data.run_last, out_data.text_done));
      end else begin
        exp = decoded_fifo.pop_front();
        if (out_data.out_byte !== exp.out_byte || out_data.out_valid !== exp.out_valid ||
            out_data.run_last !== exp.run_last || out_data.text_done !== exp.text_done) begin
          flag_error($sformatf({"mismatch byte=%h valid=%b last=%b done=%b, ",
                                "expected byte=%h valid=%b last=%b done=%b"},
                               out_data.out_byte, out_data.out_valid,
                               out_data.run_last, out_data.text_done,
                               exp.out_byte, exp.out_valid, exp.run_last, exp.text_done));
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // byte extremes: a dropped zero and a passed 0xff
  task automatic test_plain_bytes();
    push_text(xeu_pkg::CH_NUL, 1'b0);
    push_text(8'hFF, 1'b0);
  endtask

  // each named entity by its shortest prefix, the skip cut short by end of text
  task automatic test_named_entities();
    send_text("&l", 1'b1);
    send_text("&q", 1'b1);
    send_text("&g", 1'b1);
    send_text("&am", 1'b1);
    send_text("&ap", 1'b1);
  endtask

  // ampersand followed by a zero byte gives the ampersand alone
  task automatic test_stray_ampersand();
    send_text("&", 1'b0);
    push_text(xeu_pkg::CH_NUL, 1'b0);
  endtask

  // small value closed by a zero byte, hex value above 32 closed by end of text
  task automatic test_numeric_entities();
    send_text("&#9", 1'b0);
    push_text(xeu_pkg::CH_NUL, 1'b0);
    send_text("&#x21", 1'b1);
  endtask

  task automatic test_random_text();
    sender_gaps   = 1'b1;
    receiver_gaps = 1'b1;
    random_text(280);
  endtask

  // receiver holds off while the sender keeps offering, so input stalls
  task automatic test_output_stall();
    sender_gaps     = 1'b0;
    hold_off_cycles = 120;
    random_text(60);
  endtask

  // closing stretch with no idling on either side
  task automatic test_streaming();
    sender_gaps   = 1'b0;
    receiver_gaps = 1'b0;
    random_text(100);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_ni <= 1'b1;

    test_plain_bytes();
    test_named_entities();
    test_stray_ampersand();
    test_numeric_entities();
    test_random_text();
    test_output_stall();
    test_streaming();

    @(negedge clk);
    in_valid <= 1'b0;
    // drain what is still awaited, then watch for stray transfers
    while (decoded_fifo.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatch_cnt == 0 && decoded_fifo.size() == 0) begin
      $display("xml_entity_unescaper_tb: done, clean");
    end else begin
      $display("xml_entity_unescaper_tb: done, errors");
    end
    $finish;
  end

  // run limit, far above the slowest legal run
  initial begin
    #2000000;
    $display("xml_entity_unescaper_tb: done, errors");
    $finish;
  end

endmodule

/* sim.f */
src/xeu_pkg.sv
src/xeu_div10.sv
src/xeu_num_acc.sv
src/xml_entity_unescaper.sv
src/xeu_checker.sv
tb/xml_entity_unescaper_tb.sv
